FILE: rtl/segment_sphere_occlusion_test_unit_macros.svh
// assertion macros for the segment/sphere occlusion unit
// used by ssot_mac and segment_sphere_occlusion_test_unit; no other dependencies
`ifndef SEGMENT_SPHERE_OCCLUSION_TEST_UNIT_MACROS_SVH
`define SEGMENT_SPHERE_OCCLUSION_TEST_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SSOT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SSOT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ssot_pkg.sv
// shared types, widths, constants and the micro-op table of the occlusion unit
// no dependencies
package ssot_pkg;

    localparam int W   = 176;  // accumulator, signed
    localparam int XW  = 104;  // multiplicand operand, signed
    localparam int YW  = 72;   // multiplier magnitude
    localparam int PW  = 72;   // stored sums (dot products, r^2), signed
    localparam int VW  = 34;   // coordinate differences, signed
    localparam int RQW = 27;   // scaled radius
    localparam int SW  = 5;    // micro-op step index

    localparam logic [24:0] SIN5_SQ_Q32  = 25'd32625101;
    localparam logic [9:0]  RADIUS_SCALE = 10'd1010;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_TEST  = 1'b1;

    localparam logic [SW-1:0] STEP_FIRST = 5'd0;
    localparam logic [SW-1:0] STEP_END   = 5'd7;
    localparam logic [SW-1:0] STEP_MID   = 5'd16;

    typedef enum logic [4:0] {
        SRC_RQ   = 5'd0,
        SRC_V0   = 5'd1,
        SRC_V1   = 5'd2,
        SRC_V2   = 5'd3,
        SRC_D0   = 5'd4,
        SRC_D1   = 5'd5,
        SRC_D2   = 5'd6,
        SRC_W0   = 5'd7,
        SRC_W1   = 5'd8,
        SRC_W2   = 5'd9,
        SRC_E0   = 5'd10,
        SRC_E1   = 5'd11,
        SRC_E2   = 5'd12,
        SRC_R2   = 5'd13,
        SRC_DD   = 5'd14,
        SRC_WW   = 5'd15,
        SRC_P    = 5'd16,
        SRC_P32  = 5'd17,
        SRC_T    = 5'd18,
        SRC_C    = 5'd19,
        SRC_SIN5 = 5'd20
    } t_src;

    typedef enum logic [1:0] {
        INIT_ZERO = 2'd0,
        INIT_ACC  = 2'd1,
        INIT_Q    = 2'd2
    } t_init;

    typedef enum logic [3:0] {
        DST_NONE = 4'd0,
        DST_R2   = 4'd1,
        DST_VD   = 4'd2,
        DST_DD   = 4'd3,
        DST_WW   = 4'd4,
        DST_P    = 4'd5,
        DST_T    = 4'd6,
        DST_Q    = 4'd7,
        DST_C    = 4'd8,
        DST_FIN  = 4'd9
    } t_dst;

    typedef struct packed {
        t_src  x;
        t_src  y;
        logic  neg;
        t_init init;
        t_dst  dst;
    } t_uop;

    function automatic t_uop mk(t_src x, t_src y, logic neg, t_init init, t_dst dst);
        t_uop u;
        u.x = x;
        u.y = y;
        u.neg = neg;
        u.init = init;
        u.dst = dst;
        return u;
    endfunction

    // one multiply-accumulate per step; DST_NONE chains into the next step
    function automatic t_uop uop_at(logic [SW-1:0] step);
        t_uop u;
        case (step)
            5'd0:  u = mk(SRC_RQ,   SRC_RQ, 1'b0, INIT_ZERO, DST_R2);
            5'd1:  u = mk(SRC_V0,   SRC_D0, 1'b0, INIT_ZERO, DST_NONE);
            5'd2:  u = mk(SRC_V1,   SRC_D1, 1'b0, INIT_ACC,  DST_NONE);
            5'd3:  u = mk(SRC_V2,   SRC_D2, 1'b0, INIT_ACC,  DST_VD);
            5'd4:  u = mk(SRC_D0,   SRC_D0, 1'b0, INIT_ZERO, DST_NONE);
            5'd5:  u = mk(SRC_D1,   SRC_D1, 1'b0, INIT_ACC,  DST_NONE);
            5'd6:  u = mk(SRC_D2,   SRC_D2, 1'b0, INIT_ACC,  DST_DD);
            5'd7:  u = mk(SRC_W0,   SRC_W0, 1'b0, INIT_ZERO, DST_NONE);
            5'd8:  u = mk(SRC_W1,   SRC_W1, 1'b0, INIT_ACC,  DST_NONE);
            5'd9:  u = mk(SRC_W2,   SRC_W2, 1'b0, INIT_ACC,  DST_WW);
            5'd10: u = mk(SRC_E0,   SRC_W0, 1'b0, INIT_ZERO, DST_NONE);
            5'd11: u = mk(SRC_E1,   SRC_W1, 1'b0, INIT_ACC,  DST_NONE);
            5'd12: u = mk(SRC_E2,   SRC_W2, 1'b0, INIT_ACC,  DST_P);
            5'd13: u = mk(SRC_SIN5, SRC_DD, 1'b0, INIT_ZERO, DST_T);
            5'd14: u = mk(SRC_P32,  SRC_P,  1'b0, INIT_ZERO, DST_NONE);
            5'd15: u = mk(SRC_T,    SRC_WW, 1'b1, INIT_ACC,  DST_FIN);
            5'd16: u = mk(SRC_R2,   SRC_DD, 1'b1, INIT_ZERO, DST_Q);
            5'd17: u = mk(SRC_V1,   SRC_D2, 1'b0, INIT_ZERO, DST_NONE);
            5'd18: u = mk(SRC_V2,   SRC_D1, 1'b1, INIT_ACC,  DST_C);
            5'd19: u = mk(SRC_C,    SRC_C,  1'b0, INIT_Q,    DST_Q);
            5'd20: u = mk(SRC_V2,   SRC_D0, 1'b0, INIT_ZERO, DST_NONE);
            5'd21: u = mk(SRC_V0,   SRC_D2, 1'b1, INIT_ACC,  DST_C);
            5'd22: u = mk(SRC_C,    SRC_C,  1'b0, INIT_Q,    DST_Q);
            5'd23: u = mk(SRC_V0,   SRC_D1, 1'b0, INIT_ZERO, DST_NONE);
            5'd24: u = mk(SRC_V1,   SRC_D0, 1'b1, INIT_ACC,  DST_C);
            5'd25: u = mk(SRC_C,    SRC_C,  1'b0, INIT_Q,    DST_FIN);
            default: u = mk(SRC_RQ, SRC_RQ, 1'b0, INIT_ZERO, DST_FIN);
        endcase
        return u;
    endfunction

endpackage

FILE: rtl/ssot_mac.sv
// shift-add multiply-accumulate unit: acc = init +/- x*y, one multiplier bit per cycle
// depends on ssot_pkg and segment_sphere_occlusion_test_unit_macros.svh
`include "segment_sphere_occlusion_test_unit_macros.svh"

module ssot_mac (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [ssot_pkg::XW-1:0]  i_x,
    input  logic signed [ssot_pkg::XW-1:0]  i_y,
    input  logic                            i_neg,
    input  logic signed [ssot_pkg::W-1:0]   i_init,
    output logic                            o_busy,
    output logic signed [ssot_pkg::W-1:0]   o_acc
);
    localparam int W  = ssot_pkg::W;
    localparam int XW = ssot_pkg::XW;
    localparam int YW = ssot_pkg::YW;

    logic                 r_busy;
    logic                 r_sub;
    logic signed [W-1:0]  r_acc;
    logic [W-1:0]         r_mcand;
    logic [YW-1:0]        r_mplier;
    logic [XW-1:0]        x_mag;
    logic [XW-1:0]        y_mag;

    assign x_mag = i_x[XW-1] ? XW'(-i_x) : XW'(i_x);
    assign y_mag = i_y[XW-1] ? XW'(-i_y) : XW'(i_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_busy <= |r_mplier[YW-1:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= i_init;
            r_mcand  <= W'(x_mag);
            r_mplier <= y_mag[YW-1:0];
            r_sub    <= i_x[XW-1] ^ i_y[XW-1] ^ i_neg;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_sub ? r_acc - $signed(r_mcand) : r_acc + $signed(r_mcand);
            end
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_busy = r_busy;
    assign o_acc  = r_acc;

    `SSOT_ASSERT_NOW(a_start_when_free, i_clk, i_rst_n, i_start, !r_busy, "mac started while busy")
    `SSOT_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, i_start, r_busy, "mac not busy after start")

endmodule

FILE: rtl/segment_sphere_occlusion_test_unit.sv
// top level of the segment/sphere occlusion unit: body table, sequencer, operand registers
// depends on ssot_pkg, ssot_mac and segment_sphere_occlusion_test_unit_macros.svh
//
//  channel  | signals                              | direction | moves
//  ---------+--------------------------------------+-----------+------------------------------
//  in       | i_in_valid / o_in_ready + fields     | input     | body write or segment query
//  out      | o_out_valid / i_out_ready, o_blocked | output    | one word per query
//  cfg      | i_cfg_valid / o_cfg_ready            | input     | body_count register
//
// a body write leaves the sequencer idle, ready for the next item; a query reads the table
// and sets up per tested body, then runs up to 17 multiply-accumulate steps, each shifting
// through the bits of its multiplier operand, all on the single shift-add unit in ssot_mac,
// and hands its result on through a finish state
// a query stops at the first blocking body; with body_count zero it goes straight to finish
// reset (synchronous, active low) clears the sequencer, the count and the output valid;
// the body table is not cleared and holds garbage until written
// the input stays not ready while a query runs; a finished result waits in the output
// register, and a new item is taken meanwhile, stalling only when its own result is due
`include "segment_sphere_occlusion_test_unit_macros.svh"

module segment_sphere_occlusion_test_unit #(
    parameter int MAX_BODIES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // item channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_action,
    input  logic [3:0]         i_slot,
    input  logic signed [31:0] i_center_x,
    input  logic signed [31:0] i_center_y,
    input  logic signed [31:0] i_center_z,
    input  logic [15:0]        i_radius,
    input  logic signed [31:0] i_point_a_x,
    input  logic signed [31:0] i_point_a_y,
    input  logic signed [31:0] i_point_a_z,
    input  logic signed [31:0] i_point_b_x,
    input  logic signed [31:0] i_point_b_y,
    input  logic signed [31:0] i_point_b_z,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_blocked,
    // configuration channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [4:0]         i_cfg_body_count
);
    localparam int IW  = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
    localparam int CW  = $clog2(MAX_BODIES + 1);
    localparam int W   = ssot_pkg::W;
    localparam int XW  = ssot_pkg::XW;
    localparam int PW  = ssot_pkg::PW;
    localparam int VW  = ssot_pkg::VW;
    localparam int RQW = ssot_pkg::RQW;
    localparam int SW  = ssot_pkg::SW;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_READ   = 7'b0000010,
        S_SETUP  = 7'b0000100,
        S_ISSUE  = 7'b0001000,
        S_WAIT   = 7'b0010000,
        S_EVAL   = 7'b0100000,
        S_FINISH = 7'b1000000
    } t_state;

    // body table
    logic signed [31:0] mem_cx  [MAX_BODIES];
    logic signed [31:0] mem_cy  [MAX_BODIES];
    logic signed [31:0] mem_cz  [MAX_BODIES];
    logic [15:0]        mem_rad [MAX_BODIES];

    t_state              r_state, n_state;
    logic [4:0]          r_count;
    logic [CW-1:0]       r_k, n_k;
    logic [CW-1:0]       r_n;
    logic [SW-1:0]       r_step, n_step;
    logic                r_blk, n_blk;
    logic                r_out_valid, n_out_valid;
    logic                r_out_blocked;

    // read port of the table, registered
    logic signed [31:0]  r_ocx, r_ocy, r_ocz;
    logic [15:0]         r_orad;

    // query and operand registers
    logic signed [31:0]  r_a [3];
    logic signed [31:0]  r_b [3];
    logic signed [VW-1:0] r_v [3];
    logic signed [VW-1:0] r_d [3];
    logic signed [VW-1:0] r_w [3];
    logic                r_neg_e;
    logic [RQW-1:0]      r_rq;
    logic signed [PW-1:0] r_r2, r_vd, r_dd, r_ww, r_p, r_c;
    logic signed [XW-1:0] r_t;
    logic signed [W-1:0]  r_q;

    logic                in_acc;
    logic                slot_ok;
    logic [CW-1:0]       n_lim;
    logic                out_free;
    ssot_pkg::t_uop      u;
    logic signed [XW-1:0] mac_x, mac_y;
    logic signed [W-1:0]  mac_init;
    logic signed [W-1:0]  mac_acc;
    logic                mac_busy;
    logic                mac_start;
    logic signed [31:0]  o_c [3];

    // evaluation flags
    logic                acc_neg, acc_zero;
    logic                vd_le0, vd_ge_dd, end_b;
    logic                body_done, body_hit;

    assign in_acc   = i_in_valid && o_in_ready;
    assign slot_ok  = int'(i_slot) < MAX_BODIES;
    assign n_lim    = (int'(r_count) > MAX_BODIES) ? CW'(MAX_BODIES) : CW'(r_count);
    assign out_free = !r_out_valid || i_out_ready;
    assign u        = ssot_pkg::uop_at(r_step);
    assign o_c[0]   = r_ocx;
    assign o_c[1]   = r_ocy;
    assign o_c[2]   = r_ocz;

    // table write and registered read
    always_ff @(posedge i_clk) begin
        if (in_acc && i_action == ssot_pkg::ACT_WRITE && slot_ok) begin
            mem_cx[IW'(i_slot)]  <= i_center_x;
            mem_cy[IW'(i_slot)]  <= i_center_y;
            mem_cz[IW'(i_slot)]  <= i_center_z;
            mem_rad[IW'(i_slot)] <= i_radius;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ocx  <= mem_cx[r_k[IW-1:0]];
        r_ocy  <= mem_cy[r_k[IW-1:0]];
        r_ocz  <= mem_cz[r_k[IW-1:0]];
        r_orad <= mem_rad[r_k[IW-1:0]];
    end

    // operand select for the shared unit
    function automatic logic signed [XW-1:0] pick(ssot_pkg::t_src s);
        logic signed [XW-1:0] x;
        case (s)
            ssot_pkg::SRC_RQ:   x = XW'(r_rq);
            ssot_pkg::SRC_V0:   x = XW'(r_v[0]);
            ssot_pkg::SRC_V1:   x = XW'(r_v[1]);
            ssot_pkg::SRC_V2:   x = XW'(r_v[2]);
            ssot_pkg::SRC_D0:   x = XW'(r_d[0]);
            ssot_pkg::SRC_D1:   x = XW'(r_d[1]);
            ssot_pkg::SRC_D2:   x = XW'(r_d[2]);
            ssot_pkg::SRC_W0:   x = XW'(r_w[0]);
            ssot_pkg::SRC_W1:   x = XW'(r_w[1]);
            ssot_pkg::SRC_W2:   x = XW'(r_w[2]);
            ssot_pkg::SRC_E0:   x = r_neg_e ? -XW'(r_d[0]) : XW'(r_d[0]);
            ssot_pkg::SRC_E1:   x = r_neg_e ? -XW'(r_d[1]) : XW'(r_d[1]);
            ssot_pkg::SRC_E2:   x = r_neg_e ? -XW'(r_d[2]) : XW'(r_d[2]);
            ssot_pkg::SRC_R2:   x = XW'(r_r2);
            ssot_pkg::SRC_DD:   x = XW'(r_dd);
            ssot_pkg::SRC_WW:   x = XW'(r_ww);
            ssot_pkg::SRC_P:    x = XW'(r_p);
            ssot_pkg::SRC_P32:  x = XW'(r_p) <<< 32;
            ssot_pkg::SRC_T:    x = r_t;
            ssot_pkg::SRC_C:    x = XW'(r_c);
            ssot_pkg::SRC_SIN5: x = XW'(ssot_pkg::SIN5_SQ_Q32);
            default:            x = '0;
        endcase
        return x;
    endfunction

    assign mac_x     = pick(u.x);
    assign mac_y     = pick(u.y);
    assign mac_start = (r_state == S_ISSUE);

    always_comb begin
        case (u.init)
            ssot_pkg::INIT_ACC: mac_init = mac_acc;
            ssot_pkg::INIT_Q:   mac_init = r_q;
            default:            mac_init = '0;
        endcase
    end

    ssot_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mac_start),
        .i_x     (mac_x),
        .i_y     (mac_y),
        .i_neg   (u.neg),
        .i_init  (mac_init),
        .o_busy  (mac_busy),
        .o_acc   (mac_acc)
    );

    // decisions on a finished sum
    assign acc_neg  = mac_acc[W-1];
    assign acc_zero = (mac_acc == '0);
    assign vd_le0   = r_vd[PW-1] || (r_vd == '0);
    assign vd_ge_dd = r_vd >= PW'(mac_acc);
    assign end_b    = !vd_le0 && vd_ge_dd;

    always_comb begin
        body_done = 1'b0;
        body_hit  = 1'b0;
        n_step    = r_step + SW'(1);
        case (u.dst)
            ssot_pkg::DST_DD: begin
                // closest point at an endpoint, or strictly inside the segment
                n_step = (vd_le0 || vd_ge_dd) ? ssot_pkg::STEP_END : ssot_pkg::STEP_MID;
            end
            ssot_pkg::DST_WW: begin
                if (mac_acc >= W'(r_r2)) begin
                    body_done = 1'b1;
                end else if (acc_zero || r_dd == '0) begin
                    // endpoint at the centre, or zero-length segment
                    body_done = 1'b1;
                    body_hit  = 1'b1;
                end
            end
            ssot_pkg::DST_P: begin
                if (acc_neg || acc_zero) begin
                    body_done = 1'b1;
                    body_hit  = 1'b1;
                end
            end
            ssot_pkg::DST_FIN: begin
                body_done = 1'b1;
                body_hit  = acc_neg;
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_blk       = r_blk;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_action == ssot_pkg::ACT_TEST) begin
                    n_k   = '0;
                    n_blk = 1'b0;
                    n_state = (n_lim == '0) ? S_FINISH : S_READ;
                end
            end
            S_READ:  n_state = S_SETUP;
            S_SETUP: n_state = S_ISSUE;
            S_ISSUE: n_state = S_WAIT;
            S_WAIT: begin
                if (!mac_busy) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!body_done) begin
                    n_state = S_ISSUE;
                end else if (body_hit) begin
                    n_blk   = 1'b1;
                    n_state = S_FINISH;
                end else if (r_k + CW'(1) == r_n) begin
                    n_state = S_FINISH;
                end else begin
                    n_k     = r_k + CW'(1);
                    n_state = S_READ;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_k         <= '0;
            r_blk       <= 1'b0;
            r_out_valid <= 1'b0;
            r_step      <= ssot_pkg::STEP_FIRST;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_blk       <= n_blk;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_count <= i_cfg_body_count;
            end
            if (r_state == S_SETUP) begin
                r_step <= ssot_pkg::STEP_FIRST;
            end else if (r_state == S_EVAL) begin
                r_step <= n_step;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc && i_action == ssot_pkg::ACT_TEST) begin
            r_a[0] <= i_point_a_x;
            r_a[1] <= i_point_a_y;
            r_a[2] <= i_point_a_z;
            r_b[0] <= i_point_b_x;
            r_b[1] <= i_point_b_y;
            r_b[2] <= i_point_b_z;
            r_n    <= n_lim;
        end
        if (r_state == S_SETUP) begin
            for (int i = 0; i < 3; i++) begin
                r_v[i] <= VW'(o_c[i]) - VW'(r_a[i]);
                r_d[i] <= VW'(r_b[i]) - VW'(r_a[i]);
            end
            r_rq <= RQW'(r_orad) * RQW'(ssot_pkg::RADIUS_SCALE);
        end
        if (r_state == S_EVAL) begin
            case (u.dst)
                ssot_pkg::DST_R2: r_r2 <= PW'(mac_acc);
                ssot_pkg::DST_VD: r_vd <= PW'(mac_acc);
                ssot_pkg::DST_DD: begin
                    r_dd    <= PW'(mac_acc);
                    r_neg_e <= end_b;
                    // w is the chosen endpoint minus the centre
                    for (int i = 0; i < 3; i++) begin
                        r_w[i] <= end_b ? VW'(r_b[i]) - VW'(o_c[i])
                                        : VW'(r_a[i]) - VW'(o_c[i]);
                    end
                end
                ssot_pkg::DST_WW: r_ww <= PW'(mac_acc);
                ssot_pkg::DST_P:  r_p  <= PW'(mac_acc);
                ssot_pkg::DST_T:  r_t  <= XW'(mac_acc);
                ssot_pkg::DST_Q:  r_q  <= mac_acc;
                ssot_pkg::DST_C:  r_c  <= PW'(mac_acc);
                default: ;
            endcase
        end
        if (r_state == S_FINISH && out_free) begin
            r_out_blocked <= r_blk;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_blocked   = r_out_blocked;

    `SSOT_ASSERT_NOW(a_issue_mac_free, i_clk, i_rst_n, r_state == S_ISSUE, !mac_busy, "issue while mac busy")
    `SSOT_ASSERT_NOW(a_body_in_range, i_clk, i_rst_n, r_state == S_READ, r_k < r_n, "body index past count")
    `SSOT_ASSERT_NEXT(a_finish_holds, i_clk, i_rst_n, r_state == S_FINISH && r_out_valid && !i_out_ready, r_state == S_FINISH, "result dropped while output full")

endmodule

FILE: test/segment_sphere_occlusion_test_unit_tb.sv
// self-checking testbench for segment_sphere_occlusion_test_unit: directed table, then random traffic
// depends on ssot_pkg and the unit's rtl; a local integer predictor computes the expected words
module segment_sphere_occlusion_test_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  NBODY       = 16;
    localparam int  CYCLE_LIMIT = 60_000_000;
    localparam int  HOLD_CYCLES = 6000;
    localparam int  SETTLE      = 16;

    localparam logic A_WR = ssot_pkg::ACT_WRITE;
    localparam logic A_TS = ssot_pkg::ACT_TEST;

    // wide signed integer, roomy enough for the largest squared terms (about 2^168)
    typedef logic signed [199:0] t_wint;

    typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [4:0]         cfg_val;
        logic               action;
        logic [3:0]         slot;
        logic signed [31:0] c [3];
        logic [15:0]        rad;
        logic signed [31:0] pa [3];
        logic signed [31:0] pb [3];
        bit                 has_exp;
        bit                 exp_val;
    } t_item;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_action = A_WR;
    logic [3:0]         i_slot = '0;
    logic signed [31:0] i_center_x = '0, i_center_y = '0, i_center_z = '0;
    logic [15:0]        i_radius = '0;
    logic signed [31:0] i_point_a_x = '0, i_point_a_y = '0, i_point_a_z = '0;
    logic signed [31:0] i_point_b_x = '0, i_point_b_y = '0, i_point_b_z = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic               o_blocked;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [4:0]         i_cfg_body_count = '0;

    segment_sphere_occlusion_test_unit i_dut (
        .i_clk, .i_rst_n,
        .i_in_valid, .o_in_ready, .i_action, .i_slot,
        .i_center_x, .i_center_y, .i_center_z, .i_radius,
        .i_point_a_x, .i_point_a_y, .i_point_a_z,
        .i_point_b_x, .i_point_b_y, .i_point_b_z,
        .o_out_valid, .i_out_ready, .o_blocked,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_body_count
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state: own copy of the body table and the count
    logic signed [31:0] tbl_cx [NBODY];
    logic signed [31:0] tbl_cy [NBODY];
    logic signed [31:0] tbl_cz [NBODY];
    logic [15:0]        tbl_rad [NBODY];
    int unsigned        bodies_tested = 0;

    bit  blocked_q [$];      // expected blocked words, oldest first
    int  error_count = 0;
    bit  vld_shadow = 1'b0;  // what i_in_valid will hold after this step
    bit  hold_request = 1'b0;
    int  gap_mode = 0;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // endpoint case: w = P - O, e = Q - P
    function automatic bit endpoint_blocks(input t_wint wx, wy, wz, ex, ey, ez, r2);
        t_wint ww, ee, p, lhs, rhs, sin5;
        sin5 = ssot_pkg::SIN5_SQ_Q32;
        ww = wx * wx + wy * wy + wz * wz;
        if (ww >= r2) return 1'b0;
        ee = ex * ex + ey * ey + ez * ez;
        // endpoint on the centre or zero-length segment
        if (ww == 0 || ee == 0) return 1'b1;
        p = ex * wx + ey * wy + ez * wz;
        if (p <= 0) return 1'b1;
        lhs = (p * p) <<< 32;
        rhs = sin5 * ee * ww;
        return lhs < rhs;
    endfunction

    function automatic bit body_occludes(input t_wint a [3], input t_wint b [3], input int k);
        t_wint o [3], v [3], d [3];
        t_wint rq, r2, vd, dd, c0, c1, c2, cr, rad;
        o[0] = tbl_cx[k];
        o[1] = tbl_cy[k];
        o[2] = tbl_cz[k];
        rad = tbl_rad[k];
        rq = rad * 1010;
        r2 = rq * rq;
        for (int i = 0; i < 3; i++) begin
            v[i] = o[i] - a[i];
            d[i] = b[i] - a[i];
        end
        vd = v[0] * d[0] + v[1] * d[1] + v[2] * d[2];
        dd = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
        if (vd <= 0)
            return endpoint_blocks(a[0] - o[0], a[1] - o[1], a[2] - o[2], d[0], d[1], d[2], r2);
        if (vd >= dd)
            return endpoint_blocks(b[0] - o[0], b[1] - o[1], b[2] - o[2],
                                   a[0] - b[0], a[1] - b[1], a[2] - b[2], r2);
        // interior closest point: |v x d|^2 against r^2 |d|^2
        c0 = v[1] * d[2] - v[2] * d[1];
        c1 = v[2] * d[0] - v[0] * d[2];
        c2 = v[0] * d[1] - v[1] * d[0];
        cr = c0 * c0 + c1 * c1 + c2 * c2;
        return cr < r2 * dd;
    endfunction

    function automatic bit segment_blocked(input t_item it);
        t_wint a [3], b [3];
        for (int i = 0; i < 3; i++) begin
            a[i] = it.pa[i];
            b[i] = it.pb[i];
        end
        for (int k = 0; k < int'(bodies_tested); k++)
            if (body_occludes(a, b, k)) return 1'b1;
        return 1'b0;
    endfunction

    // update the table or queue the expected word once an item is taken
    task automatic absorb_item(input t_item it);
        bit hit;
        if (it.action == A_WR) begin
            tbl_cx[it.slot]  = it.c[0];
            tbl_cy[it.slot]  = it.c[1];
            tbl_cz[it.slot]  = it.c[2];
            tbl_rad[it.slot] = it.rad;
        end else begin
            hit = segment_blocked(it);
            if (it.has_exp && it.exp_val != hit)
                report_mismatch($sformatf("table row expects %0d, predictor gives %0d",
                                          it.exp_val, hit));
            blocked_q.push_back(it.has_exp ? it.exp_val : hit);
        end
    endtask

    task automatic release_valid();
        if (vld_shadow) begin
            i_in_valid <= 1'b0;
            vld_shadow = 1'b0;
        end
    endtask

    // offer one word, wait for the handshake, then maybe leave a gap
    task automatic offer(input t_item it);
        int gap;
        i_in_valid  <= 1'b1;
        vld_shadow  = 1'b1;
        i_action    <= it.action;
        i_slot      <= it.slot;
        i_center_x  <= it.c[0];
        i_center_y  <= it.c[1];
        i_center_z  <= it.c[2];
        i_radius    <= it.rad;
        i_point_a_x <= it.pa[0];
        i_point_a_y <= it.pa[1];
        i_point_a_z <= it.pa[2];
        i_point_b_x <= it.pb[0];
        i_point_b_y <= it.pb[1];
        i_point_b_z <= it.pb[2];
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        absorb_item(it);
        // bursty sender: mode 0 never idles
        gap = 0;
        if (gap_mode != 0 && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 12);
        if (gap > 0) begin
            release_valid();
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // body_count is only written with the unit idle
    task automatic set_body_count(input logic [4:0] n);
        release_valid();
        while (blocked_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid      <= 1'b1;
        i_cfg_body_count <= n;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        bodies_tested = (n > NBODY) ? NBODY : n;
    endtask

    function automatic logic signed [31:0] pick_coord(input bit wide);
        if (wide) return $urandom;
        return $signed($urandom_range(0, 4_000_000)) - 2_000_000;
    endfunction

    function automatic t_item new_item(input logic act);
        t_item it;
        bit wide;
        it.kind    = ROW_ITEM;
        it.cfg_val = '0;
        it.action  = act;
        it.slot    = $urandom_range(0, 15);
        it.has_exp = 1'b0;
        it.exp_val = 1'b0;
        wide = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < 3; i++) begin
            it.c[i]  = pick_coord(wide);
            it.pa[i] = pick_coord(wide);
            it.pb[i] = pick_coord(wide);
        end
        it.rad = wide ? 16'($urandom) : 16'($urandom_range(0, 2500));
        return it;
    endfunction

    // random query, often aimed near a tested body so that blocking happens
    function automatic t_item new_query();
        t_item it;
        int k, span;
        it = new_item(A_TS);
        if (bodies_tested != 0 && $urandom_range(0, 9) < 6) begin
            k = $urandom_range(0, bodies_tested - 1);
            span = $urandom_range(0, 1) ? 2_000_000 : 50_000;
            it.pa[0] = tbl_cx[k] + ($signed($urandom_range(0, 2 * span)) - span);
            it.pa[1] = tbl_cy[k] + ($signed($urandom_range(0, 2 * span)) - span);
            it.pa[2] = tbl_cz[k] + ($signed($urandom_range(0, 2 * span)) - span);
            case ($urandom_range(0, 3))
                0: it.pb = it.pa;                               // zero-length segment
                1: for (int i = 0; i < 3; i++)                  // through the centre
                       it.pb[i] = 2 * (k == 0 ? tbl_cx[0] : tbl_cx[k]) * (i == 0)
                                  + 2 * tbl_cy[k] * (i == 1) + 2 * tbl_cz[k] * (i == 2)
                                  - it.pa[i];
                default: for (int i = 0; i < 3; i++)
                       it.pb[i] = it.pa[i] + ($signed($urandom_range(0, 2 * span)) - span);
            endcase
        end
        return it;
    endfunction

    function automatic t_item row(input t_row_kind kind, input logic [4:0] cfg,
                                  input logic act, input logic [3:0] slot,
                                  input logic signed [31:0] cx, cy, cz, input logic [15:0] rad,
                                  input logic signed [31:0] ax, ay, az, bx, by, bz,
                                  input bit has_exp, input bit exp_val);
        t_item it;
        it.kind = kind;
        it.cfg_val = cfg;
        it.action = act;
        it.slot = slot;
        it.c[0] = cx;  it.c[1] = cy;  it.c[2] = cz;
        it.rad = rad;
        it.pa[0] = ax; it.pa[1] = ay; it.pa[2] = az;
        it.pb[0] = bx; it.pb[1] = by; it.pb[2] = bz;
        it.has_exp = has_exp;
        it.exp_val = exp_val;
        return it;
    endfunction

    localparam logic signed [31:0] PMAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] PMIN = 32'sh8000_0000;

    // receiver: stall pattern of its own, plus one long hold-off on request
    int hold_left = 0;
    int recv_mode = 0;
    int recv_tick = 0;
    always @(posedge i_clk) begin
        recv_tick <= recv_tick + 1;
        if (recv_tick % 256 == 0) recv_mode <= $urandom_range(0, 2);
        if (hold_request && hold_left == 0) begin
            hold_left    <= HOLD_CYCLES;
            hold_request <= 1'b0;
            i_out_ready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            case (recv_mode)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= $urandom_range(0, 1);
                default: i_out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (blocked_q.size() == 0)
                report_mismatch($sformatf("unexpected word, blocked=%0d", o_blocked));
            else if (o_blocked !== blocked_q[0]) begin
                report_mismatch($sformatf("blocked=%0d, expected %0d", o_blocked, blocked_q[0]));
                void'(blocked_q.pop_front());
            end else
                void'(blocked_q.pop_front());
        end
    end

    // watchdog
    int cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("segment_sphere_occlusion_test_unit regression: fail");
            $finish;
        end
    end

    t_item directed [$];
    t_item it;
    int    n_items;
    logic [4:0] phase_counts [12] = '{5'd16, 5'd1, 5'd2, 5'd3, 5'd31, 5'd0,
                                      5'd4, 5'd17, 5'd1, 5'd2, 5'd8, 5'd16};

    initial begin
        // directed table: extremes, both actions, the special cases
        directed = '{
            // count zero after reset: never blocked
            row(ROW_ITEM, 0, A_TS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0),
            row(ROW_ITEM, 0, A_WR, 0, 0, 0, 0, 16'd1, 0, 0, 0, 0, 0, 0, 0, 0),
            row(ROW_ITEM, 0, A_WR, 1, PMAX, PMAX, PMAX, 16'hffff, 0, 0, 0, 0, 0, 0, 0, 0),
            row(ROW_ITEM, 0, A_WR, 2, PMIN, PMIN, PMIN, 16'd0, 0, 0, 0, 0, 0, 0, 0, 0),
            row(ROW_ITEM, 0, A_WR, 3, 10000, 0, 0, 16'd2, 0, 0, 0, 0, 0, 0, 0, 0),
            row(ROW_CFG, 5'd1, A_TS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
            // zero-length segment at the centre
            row(ROW_ITEM, 0, A_TS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1),
            // straight through the centre, interior closest point
            row(ROW_ITEM, 0, A_TS, 0, 0, 0, 0, 0, -5000, 0, 0, 5000, 0, 0, 0, 0),
            // well outside
            row(ROW_ITEM, 0, A_TS, 0, 0, 0, 0, 0, 2000, 0, 0, 3000, 0, 0, 0, 0),
            // start inside, leaving straight outward
            row(ROW_ITEM, 0, A_TS, 0, 0, 0, 0, 0, 500, 0, 0, 3000, 0, 0, 0, 0),
            // start inside, crossing the centre
            row(ROW_ITEM, 0, A_TS, 0, 0, 0, 0, 0, 500, 0, 0, -3000, 0, 0, 0, 0),
            // start inside, leaving tangentially
            row(ROW_ITEM, 0, A_TS, 0, 0, 0, 0, 0, 500, 0, 0, 500, 5000, 0, 0, 0),
            // corner to corner
            row(ROW_ITEM, 0, A_TS, 0, 0, 0, 0, 0, PMAX, PMAX, PMAX, PMIN, PMIN, PMIN, 0, 0),
            row(ROW_CFG, 5'd4, A_TS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
            row(ROW_ITEM, 0, A_TS, 0, 0, 0, 0, 0, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, 0, 0),
            row(ROW_ITEM, 0, A_TS, 0, 0, 0, 0, 0, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, 1, 1),
            row(ROW_ITEM, 0, A_TS, 0, 0, 0, 0, 0, 9000, 0, 0, 9000, 0, 0, 0, 0),
            row(ROW_ITEM, 0, A_TS, 0, 0, 0, 0, 0, PMIN, PMAX, PMIN, PMAX, PMIN, PMAX, 0, 0),
            row(ROW_ITEM, 0, A_WR, 15, PMAX, PMIN, -1, 16'hffff, 0, 0, 0, 0, 0, 0, 0, 0),
            row(ROW_CFG, 5'd0, A_TS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[r]) begin
            if (directed[r].kind == ROW_CFG)
                set_body_count(directed[r].cfg_val);
            else
                offer(directed[r]);
        end

        // fill every slot before any count can reach it
        for (int s = 0; s < NBODY; s++) begin
            it = new_item(A_WR);
            it.slot = s;
            offer(it);
        end

        foreach (phase_counts[p]) begin
            set_body_count(phase_counts[p]);
            gap_mode = (p % 3 == 0) ? 0 : 1;
            // one long receiver hold-off while the sender keeps pushing queries
            if (p == 1) hold_request = 1'b1;
            n_items = (bodies_tested >= 8) ? 30 : 100;
            for (int i = 0; i < n_items; i++) begin
                if ($urandom_range(0, 9) < 5)
                    offer(new_item(A_WR));
                else
                    offer(new_query());
            end
        end

        release_valid();
        while (blocked_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (error_count == 0)
            $display("segment_sphere_occlusion_test_unit regression: pass");
        else
            $display("segment_sphere_occlusion_test_unit regression: fail");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/ssot_pkg.sv
rtl/ssot_mac.sv
rtl/segment_sphere_occlusion_test_unit.sv
test/segment_sphere_occlusion_test_unit_tb.sv
